// ----- rtl/core/afc_pkg.sv -----
// Shared types and constants for the box against frustum culling block.
package afc_pkg;

  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NUM_COMPS = 4;
  localparam int unsigned MATRIX_DIM = 4;
  localparam int unsigned D_SHIFT = 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    PLANE_LEFT   = 3'd0,
    PLANE_RIGHT  = 3'd1,
    PLANE_BOTTOM = 3'd2,
    PLANE_TOP    = 3'd3,
    PLANE_NEAR   = 3'd4,
    PLANE_FAR    = 3'd5,
    PLANE_NONE   = 3'd6
  } plane_e;

endpackage

// ----- rtl/core/aabb_frustum_cull.sv -----
// Axis-aligned box against view frustum culling, positive-corner test on six planes.
// A test item's result passes through the plane evaluation pipeline and an output register before it appears.
// Throughput: one item per cycle while the output is not stalled; all six planes are evaluated in parallel lanes.
// Load items write the matrix at acceptance and produce no result.
// Reset clears the matrix to zero and empties the pipeline; there is no clearing pass.
module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [1:0]                    matrix_row_i,
  input  logic [1:0]                    matrix_col_i,
  input  logic signed [COEF_WIDTH-1:0]  coefficient_i,
  input  logic signed [COORD_WIDTH-1:0] min_x_i,
  input  logic signed [COORD_WIDTH-1:0] min_y_i,
  input  logic signed [COORD_WIDTH-1:0] min_z_i,
  input  logic signed [COORD_WIDTH-1:0] max_x_i,
  input  logic signed [COORD_WIDTH-1:0] max_y_i,
  input  logic signed [COORD_WIDTH-1:0] max_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o,
  output logic [2:0]                    culled_plane_o
);

  localparam int unsigned PW = COEF_WIDTH + 1;
  localparam int unsigned LANE_STAGES = 5;
  localparam int unsigned MAT_ENTRIES = MATRIX_DIM * MATRIX_DIM;

  logic signed [COEF_WIDTH-1:0]  mat_q [MAT_ENTRIES];
  logic signed [COORD_WIDTH-1:0] box_min [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] box_max [NUM_AXES];
  logic signed [PW-1:0]          plane [NUM_PLANES][NUM_COMPS];
  logic [NUM_PLANES-1:0]         cull;
  logic [LANE_STAGES-1:0]        valid_q;
  logic                          out_valid_q;
  logic                          inside_q;
  plane_e                        plane_q;
  plane_e                        plane_d;
  logic                          en;
  logic                          in_fire;

  assign en = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign in_fire = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAT_ENTRIES; i++) begin
        mat_q[i] <= '0;
      end
    end else if (in_fire && (op_e'(operation_i) == OP_LOAD)) begin
      mat_q[{matrix_row_i, matrix_col_i}] <= coefficient_i;
    end
  end

  assign box_min[0] = min_x_i;
  assign box_min[1] = min_y_i;
  assign box_min[2] = min_z_i;
  assign box_max[0] = max_x_i;
  assign box_max[1] = max_y_i;
  assign box_max[2] = max_z_i;

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_plane
    for (genvar c = 0; c < NUM_COMPS; c++) begin : g_comp
      if ((k % 2) == 1) begin : g_sub
        assign plane[k][c] = PW'(mat_q[(MATRIX_DIM - 1) * MATRIX_DIM + c])
                           - PW'(mat_q[(k / 2) * MATRIX_DIM + c]);
      end else begin : g_add
        assign plane[k][c] = PW'(mat_q[(MATRIX_DIM - 1) * MATRIX_DIM + c])
                           + PW'(mat_q[(k / 2) * MATRIX_DIM + c]);
      end
    end

    afc_plane_eval #(
      .COEF_WIDTH (COEF_WIDTH),
      .COORD_WIDTH(COORD_WIDTH)
    ) u_eval (
      .clk_i    (clk_i),
      .en_i     (en),
      .plane_i  (plane[k]),
      .box_min_i(box_min),
      .box_max_i(box_max),
      .cull_o   (cull[k])
    );
  end

  always_comb begin
    plane_d = PLANE_NONE;
    for (int k = NUM_PLANES - 1; k >= 0; k--) begin
      if (cull[k]) begin
        plane_d = plane_e'(3'(k));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[LANE_STAGES-2:0],
                      in_valid_i && (op_e'(operation_i) == OP_TEST)};
      out_valid_q <= valid_q[LANE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      plane_q  <= plane_d;
      inside_q <= (cull == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign inside_res_o = inside_q;
  assign culled_plane_o = plane_q;

  a_test_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_e'(operation_i) == OP_TEST)) |=> valid_q[0])
    else $error("accepted test item did not enter the pipeline");

  a_load_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_e'(operation_i) == OP_LOAD)) |=> !valid_q[0])
    else $error("load item took a pipeline slot");

  a_inside_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (inside_q == (plane_q == PLANE_NONE)))
    else $error("inside flag disagrees with culled plane");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("pipeline moved while stalled");

endmodule

// ----- rtl/core/afc_plane_eval.sv -----
// Pipelined test of one box corner against one plane, split multiply and staged sum.
module afc_plane_eval
  import afc_pkg::*;
#(
  parameter int unsigned COEF_WIDTH = 32,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COEF_WIDTH:0]    plane_i [NUM_COMPS],
  input  logic signed [COORD_WIDTH-1:0] box_min_i [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] box_max_i [NUM_AXES],
  output logic                          cull_o
);

  localparam int unsigned PW = COEF_WIDTH + 1;
  localparam int unsigned LO_W = COORD_WIDTH / 2;
  localparam int unsigned HI_W = COORD_WIDTH - LO_W;
  localparam int unsigned PPH_W = PW + HI_W;
  localparam int unsigned PPL_W = PW + LO_W + 1;
  localparam int unsigned PROD_W = PW + COORD_WIDTH;
  localparam int unsigned HALF_W = PROD_W + 1;
  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned DS_W = PW + D_SHIFT;

  logic signed [PW-1:0]          n1_q [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] p1_q [NUM_AXES];
  logic signed [PW-1:0]          d1_q;
  logic                          zero1_q;

  logic signed [PPH_W-1:0]       pph2_q [NUM_AXES];
  logic signed [PPL_W-1:0]       ppl2_q [NUM_AXES];
  logic signed [PW-1:0]          d2_q;
  logic                          zero2_q;

  logic signed [PROD_W-1:0]      prod3_q [NUM_AXES];
  logic signed [PW-1:0]          d3_q;
  logic                          zero3_q;

  logic signed [HALF_W-1:0]      sa4_q;
  logic signed [HALF_W-1:0]      sb4_q;
  logic                          zero4_q;

  logic                          cull5_q;

  logic signed [DS_W-1:0]        d_aligned;
  logic signed [SUM_W-1:0]       sum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        n1_q[a] <= plane_i[a];
        p1_q[a] <= plane_i[a][PW-1] ? box_min_i[a] : box_max_i[a];
      end
      d1_q    <= plane_i[NUM_COMPS-1];
      zero1_q <= (plane_i[0] == '0) && (plane_i[1] == '0) && (plane_i[2] == '0);

      for (int a = 0; a < NUM_AXES; a++) begin
        pph2_q[a] <= PPH_W'(n1_q[a] * $signed(p1_q[a][COORD_WIDTH-1:LO_W]));
        ppl2_q[a] <= PPL_W'(n1_q[a] * $signed({1'b0, p1_q[a][LO_W-1:0]}));
      end
      d2_q    <= d1_q;
      zero2_q <= zero1_q;

      for (int a = 0; a < NUM_AXES; a++) begin
        prod3_q[a] <= (PROD_W'(pph2_q[a]) <<< LO_W) + PROD_W'(ppl2_q[a]);
      end
      d3_q    <= d2_q;
      zero3_q <= zero2_q;

      sa4_q   <= HALF_W'(prod3_q[0]) + HALF_W'(prod3_q[1]);
      sb4_q   <= HALF_W'(prod3_q[2]) + HALF_W'(d_aligned);
      zero4_q <= zero3_q;

      cull5_q <= !zero4_q && sum[SUM_W-1];
    end
  end

  assign d_aligned = $signed({d3_q, {D_SHIFT{1'b0}}});
  assign sum = SUM_W'(sa4_q) + SUM_W'(sb4_q);
  assign cull_o = cull5_q;

endmodule

// ----- tb/aabb_frustum_cull_test.sv -----
// Self-checking testbench for the box against frustum culling block with its own predictor.
module aabb_frustum_cull_test
  import afc_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [31:0] ONE_COEF = 32'h0001_0000;
  localparam int ONE_COORD = 256;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7fff_ffff;

  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
  } box_t;

  typedef struct packed {
    logic   is_inside;
    plane_e plane;
  } verdict_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = OP_LOAD;
  logic [1:0] matrix_row_i = '0;
  logic [1:0] matrix_col_i = '0;
  logic signed [31:0] coefficient_i = '0;
  logic signed [31:0] min_x_i = '0;
  logic signed [31:0] min_y_i = '0;
  logic signed [31:0] min_z_i = '0;
  logic signed [31:0] max_x_i = '0;
  logic signed [31:0] max_y_i = '0;
  logic signed [31:0] max_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic inside_res_o;
  logic [2:0] culled_plane_o;

  logic signed [31:0] view_proj_model [16];
  verdict_t expected_verdicts [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit sender_gap_en = 1'b1;
  bit receiver_stall_en = 1'b1;

  aabb_frustum_cull i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .matrix_row_i   (matrix_row_i),
    .matrix_col_i   (matrix_col_i),
    .coefficient_i  (coefficient_i),
    .min_x_i        (min_x_i),
    .min_y_i        (min_y_i),
    .min_z_i        (min_z_i),
    .max_x_i        (max_x_i),
    .max_y_i        (max_y_i),
    .max_z_i        (max_z_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inside_res_o   (inside_res_o),
    .culled_plane_o (culled_plane_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic plane_e predict_culling_plane(input box_t box);
    logic signed [31:0] corner_lo [3];
    logic signed [31:0] corner_hi [3];
    logic signed [32:0] base, other;
    logic signed [32:0] comp [4];
    logic signed [71:0] acc, comp_w, corner_w;
    int k, c, a;
    corner_lo[0] = box.min_x;
    corner_lo[1] = box.min_y;
    corner_lo[2] = box.min_z;
    corner_hi[0] = box.max_x;
    corner_hi[1] = box.max_y;
    corner_hi[2] = box.max_z;
    for (k = 0; k < NUM_PLANES; k++) begin
      for (c = 0; c < NUM_COMPS; c++) begin
        base = 33'(view_proj_model[12 + c]);
        other = 33'(view_proj_model[(k / 2) * 4 + c]);
        comp[c] = (k % 2 == 1) ? base - other : base + other;
      end
      if (comp[0] != 0 || comp[1] != 0 || comp[2] != 0) begin
        acc = 72'(comp[3]);
        acc = acc <<< D_SHIFT;
        for (a = 0; a < NUM_AXES; a++) begin
          comp_w = 72'(comp[a]);
          corner_w = 72'(comp[a][32] ? corner_lo[a] : corner_hi[a]);
          acc = acc + comp_w * corner_w;
        end
        if (acc[71]) begin
          return plane_e'(k[2:0]);
        end
      end
    end
    return PLANE_NONE;
  endfunction

  function automatic box_t make_box(input int lx, ly, lz, hx, hy, hz);
    box_t b;
    b.min_x = lx;
    b.min_y = ly;
    b.min_z = lz;
    b.max_x = hx;
    b.max_y = hy;
    b.max_z = hz;
    return b;
  endfunction

  function automatic box_t rand_box();
    logic [31:0] lo [3];
    logic [31:0] hi [3];
    logic [31:0] tmp;
    int a;
    for (a = 0; a < 3; a++) begin
      case ($urandom_range(0, 15))
        0: begin
          lo[a] = $urandom;
          hi[a] = $urandom;
        end
        1: begin
          lo[a] = MOST_NEG;
          hi[a] = MOST_POS;
        end
        default: begin
          lo[a] = $urandom_range(0, 16384) - 8192;
          hi[a] = lo[a] + $urandom_range(0, 1024);
        end
      endcase
      if ($urandom_range(0, 9) == 0) begin
        tmp = lo[a];
        lo[a] = hi[a];
        hi[a] = tmp;
      end
    end
    return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  function automatic logic [31:0] rand_coef(input bit frustum_like, input int idx);
    if (frustum_like) begin
      if (idx == 15) begin
        return $urandom_range(65536, 16 * 65536);
      end else if (idx < 12 && idx % 5 == 0) begin
        return $urandom_range(16384, 262144);
      end else if ($urandom_range(0, 1) == 0) begin
        return '0;
      end
      return $urandom_range(0, 32768) - 16384;
    end
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? MOST_POS : MOST_NEG;
      2, 3: return '0;
      default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
    endcase
  endfunction

  task automatic send_item(input op_e op, input logic [1:0] row, input logic [1:0] col,
                           input logic [31:0] coef, input box_t box);
    verdict_t verdict;
    while (sender_gap_en && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    matrix_row_i <= row;
    matrix_col_i <= col;
    coefficient_i <= coef;
    min_x_i <= box.min_x;
    min_y_i <= box.min_y;
    min_z_i <= box.min_z;
    max_x_i <= box.max_x;
    max_y_i <= box.max_y;
    max_z_i <= box.max_z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (op == OP_LOAD) begin
      view_proj_model[{row, col}] = coef;
    end else begin
      verdict.plane = predict_culling_plane(box);
      verdict.is_inside = (verdict.plane == PLANE_NONE);
      expected_verdicts.insert(expected_verdicts.size(), verdict);
    end
  endtask

  task automatic load_coef(input int row, input int col, input logic [31:0] coef);
    send_item(OP_LOAD, row[1:0], col[1:0], coef, rand_box());
  endtask

  task automatic test_box(input box_t box);
    send_item(OP_TEST, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom, box);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_cleared_matrix();
    test_box(make_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS));
  endtask

  task automatic test_each_plane();
    int u;
    int h;
    u = ONE_COORD;
    h = ONE_COORD / 2;
    load_coef(0, 0, ONE_COEF);
    load_coef(1, 1, ONE_COEF);
    load_coef(2, 2, ONE_COEF);
    load_coef(3, 3, ONE_COEF);
    test_box(make_box(-h, -h, -h, h, h, h));
    test_box(make_box(-5 * u, -h, -h, -3 * u, h, h));
    test_box(make_box(3 * u, -h, -h, 5 * u, h, h));
    test_box(make_box(-h, -5 * u, -h, h, -3 * u, h));
    test_box(make_box(-h, 3 * u, -h, h, 5 * u, h));
    test_box(make_box(-h, -h, -5 * u, h, h, -3 * u));
    test_box(make_box(-h, -h, 3 * u, h, h, 5 * u));
    // The left plane passes exactly through the maximum x of this box.
    test_box(make_box(-3 * u, -h, -h, -u, h, h));
    // An inverted box keeps the corner choice, so the left plane sees max x.
    test_box(make_box(5 * u, -h, -h, -5 * u, h, h));
  endtask

  task automatic test_zero_normal();
    load_coef(0, 0, '0);
    load_coef(1, 1, '0);
    load_coef(2, 2, '0);
    load_coef(3, 3, -ONE_COEF);
    test_box(make_box(-ONE_COORD, -ONE_COORD, -ONE_COORD, ONE_COORD, ONE_COORD, ONE_COORD));
  endtask

  task automatic test_extreme_values();
    load_coef(0, 0, MOST_POS);
    load_coef(3, 0, MOST_NEG);
    load_coef(0, 3, MOST_NEG);
    load_coef(3, 3, MOST_POS);
    test_box(make_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS));
    test_box(make_box(MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG));
  endtask

  task automatic test_random_frames(input int target);
    int frame_no;
    int n, i, idx;
    bit frustum_like;
    frame_no = 0;
    while (items_sent < target) begin
      frustum_like = ($urandom_range(0, 4) < 3);
      if (!frustum_like && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          idx = $urandom_range(0, 15);
          load_coef(idx / 4, idx % 4, rand_coef(1'b0, idx));
        end
      end else begin
        for (idx = 0; idx < 16; idx++) begin
          load_coef(idx / 4, idx % 4, rand_coef(frustum_like, idx));
        end
      end
      n = $urandom_range(10, 40);
      for (i = 0; i < n; i++) begin
        test_box(rand_box());
      end
      if (frame_no % 6 == 5) begin
        wait_drained();
      end
      frame_no++;
    end
  endtask

  task automatic test_back_to_back();
    sender_gap_en = 1'b0;
    receiver_stall_en = 1'b0;
    test_random_frames(items_sent + 150);
    sender_gap_en = 1'b1;
    receiver_stall_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      view_proj_model[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_cleared_matrix();
    test_each_plane();
    test_zero_normal();
    test_extreme_values();
    wait_drained();
    test_back_to_back();
    test_random_frames(RANDOM_ITEMS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    out_stall_i <= receiver_stall_en && ($urandom_range(0, 99) < 15);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("Unexpected result: inside=%0d plane=%0d", inside_res_o, culled_plane_o);
        end
        mismatch_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (inside_res_o !== want.is_inside || culled_plane_o !== want.plane) begin
          if (mismatch_count < 10) begin
            $display("Mismatch: expected inside=%0d plane=%0d, got inside=%0d plane=%0d",
                     want.is_inside, want.plane, inside_res_o, culled_plane_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
